// ----- design/modbus_rtu_master_framer_macros.svh -----
// assertion macros used by the framer checker
`ifndef MODBUS_RTU_MASTER_FRAMER_MACROS_SVH
`define MODBUS_RTU_MASTER_FRAMER_MACROS_SVH

// same-cycle implication
`define MRMF_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("mrmf check failed");

// next-cycle implication
`define MRMF_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("mrmf check failed");

`endif

// ----- design/mrmf_pkg.sv -----
// types, codes and the crc step shared by the framer modules
package mrmf_pkg;

	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_WDATA   = 2'd1,
		REQ_RXBYTE  = 2'd2,
		REQ_TIMEOUT = 2'd3
	} req_t;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_FUNC    = 3'd1;
	localparam logic [2:0] ST_BAD_FRAME   = 3'd2;
	localparam logic [2:0] ST_TIMEOUT     = 3'd3;
	localparam logic [2:0] ST_WRONG_SLAVE = 3'd4;

	localparam logic [7:0] FN_READ_HOLD   = 8'h03;
	localparam logic [7:0] FN_READ_INPUT  = 8'h04;
	localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FN_WRITE_REG   = 8'h06;
	localparam logic [7:0] FN_EXC_STATUS  = 8'h07;
	localparam logic [7:0] FN_DIAG        = 8'h08;
	localparam logic [7:0] FN_WRITE_MULTI = 8'h10;

	localparam logic [15:0] CRC_INIT = 16'hffff;
	localparam logic [15:0] CRC_POLY = 16'ha001;

	localparam logic [8:0] LEN_BAND1 = 9'd17;
	localparam logic [8:0] LEN_BAND2 = 9'd18;
	localparam logic [8:0] LEN_BAND3 = 9'd19;
	localparam logic [8:0] LEN_WRITE = 9'd8;
	localparam logic [8:0] LEN_EXC   = 9'd5;

	localparam int MAX_READ_WORDS = 13;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = 2;

	typedef struct packed {
		req_t        req;
		logic [7:0]  slave;
		logic [7:0]  function_req;
		logic [15:0] address;
		logic [6:0]  quantity;
		logic [15:0] data_word;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- design/modbus_rtu_master_framer.sv -----
// Modbus RTU master framer. Items enter a four-deep queue, so the input side keeps
// accepting until it is full while the engine works. The engine decodes each item,
// then sends its results through the output register, one per cycle unless stalled.
// A start with an unknown function gives a status only, a known one its frame bytes
// plus CRC. A function 16 data word gives two bytes, the last one plus CRC; a timeout
// in a transaction a status; the byte completing a response up to 13 read words and
// a status. The CRC is computed byte by byte as frame bytes leave and response bytes
// arrive, so the final check needs no buffer pass; read words are packed on arrival.
module modbus_rtu_master_framer #(
	parameter int RX_BUF_BYTES    = 32,
	parameter int MAX_WRITE_WORDS = 123
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  slave,
	input  logic [7:0]  function_req,
	input  logic [15:0] address,
	input  logic [6:0]  quantity,
	input  logic [15:0] data_word,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  tx_byte,
	output logic [15:0] data_value,
	output logic [2:0]  status,
	output logic        last
);
	import mrmf_pkg::*;

	q_head_t head;
	logic    pop;

	mrmf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.slave        (slave),
		.function_req (function_req),
		.address      (address),
		.quantity     (quantity),
		.data_word    (data_word),
		.rx_byte      (rx_byte),
		.head         (head),
		.pop          (pop)
	);

	mrmf_back #(
		.RX_BUF_BYTES    (RX_BUF_BYTES),
		.MAX_WRITE_WORDS (MAX_WRITE_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_kind   (out_kind),
		.tx_byte    (tx_byte),
		.data_value (data_value),
		.status     (status),
		.last       (last)
	);

endmodule

// ----- design/mrmf_front.sv -----
// front end: takes items, tags their kind and queues them for the engine
module mrmf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_type,
	input  logic [7:0]        slave,
	input  logic [7:0]        function_req,
	input  logic [15:0]       address,
	input  logic [6:0]        quantity,
	input  logic [15:0]       data_word,
	input  logic [7:0]        rx_byte,
	output mrmf_pkg::q_head_t head,
	input  logic              pop
);
	import mrmf_pkg::*;

	item_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	item_t              item_in;
	logic               push;
	logic               do_pop;

	always_comb begin
		item_in.slave        = slave;
		item_in.function_req = function_req;
		item_in.address      = address;
		item_in.quantity     = quantity;
		item_in.data_word    = data_word;
		item_in.rx_byte      = rx_byte;
		case (req_type)
			2'd0: item_in.req = REQ_START;
			2'd1: item_in.req = REQ_WDATA;
			2'd2: item_in.req = REQ_RXBYTE;
			default: item_in.req = REQ_TIMEOUT;
		endcase
	end

	assign req_ready  = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign push       = req_valid && req_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = fifo_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/mrmf_back.sv -----
// back end: protocol engine, frame sequencer and result register
module mrmf_back #(
	parameter int RX_BUF_BYTES    = 32,
	parameter int MAX_WRITE_WORDS = 123
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrmf_pkg::q_head_t head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        out_kind,
	output logic [7:0]        tx_byte,
	output logic [15:0]       data_value,
	output logic [2:0]        status,
	output logic              last
);
	import mrmf_pkg::*;

	localparam int CW = $clog2(RX_BUF_BYTES + 1);

	typedef enum logic [3:0] {
		S_DECODE = 4'b0001,
		S_TX     = 4'b0010,
		S_WORDS  = 4'b0100,
		S_STATUS = 4'b1000
	} seq_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_WDATA = 3'b010,
		PH_RECV  = 3'b100
	} phase_t;

	seq_t        state_q, state_d;
	phase_t      phase_q, phase_d;
	logic        order_low_q, order_low_d;
	logic [7:0]  slave_q, slave_d;
	logic [7:0]  func_q, func_d;
	logic [6:0]  qty_q, qty_d;
	logic [6:0]  words_left_q, words_left_d;
	logic [15:0] tx_crc_q, tx_crc_d;
	logic [15:0] rx_crc_q, rx_crc_d;
	logic [CW-1:0] rx_count_q, rx_count_d;
	logic [CW-1:0] exp_len_q, exp_len_d;
	logic        seen_nz_q, seen_nz_d;
	logic [7:0]  byte0_q, byte0_d;
	logic [7:0]  byte1_q, byte1_d;
	logic [7:0]  byte2_q, byte2_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  hi_q, hi_d;
	logic [7:0]  frame_q [7];
	logic [7:0]  frame_d [7];
	logic [2:0]  frame_n_q, frame_n_d;
	logic [2:0]  frame_idx_q, frame_idx_d;
	logic        tail_q, tail_d;
	logic        in_crc_q, in_crc_d;
	logic        crc_idx_q, crc_idx_d;
	logic [3:0]  word_cnt_q, word_cnt_d;
	logic [3:0]  word_idx_q, word_idx_d;
	logic        word7_q, word7_d;
	logic [2:0]  stat_q, stat_d;
	logic [15:0] wmem_q [MAX_READ_WORDS];

	logic        wr_word;
	logic [3:0]  wr_idx;
	logic [15:0] wr_data;

	logic        emit;
	logic [1:0]  e_kind;
	logic [7:0]  e_tx;
	logic [15:0] e_val;
	logic [2:0]  e_st;
	logic        e_last;

	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_q;
	logic [15:0] val_q;
	logic [2:0]  st_q;
	logic        last_q;

	logic        slot_free;

	// decode temporaries
	logic [7:0]  s, f, b;
	logic [6:0]  qs;
	logic [8:0]  len_raw;
	logic        known;
	logic        rd;
	logic [CW:0] k1, k2;
	logic [8:0]  off;
	logic [8:0]  hl;
	logic [2:0]  st;
	logic        crc_ok;
	logic [7:0]  cur_byte;
	logic [6:0]  wl_next;

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		order_low_d  = order_low_q;
		slave_d      = slave_q;
		func_d       = func_q;
		qty_d        = qty_q;
		words_left_d = words_left_q;
		tx_crc_d     = tx_crc_q;
		rx_crc_d     = rx_crc_q;
		rx_count_d   = rx_count_q;
		exp_len_d    = exp_len_q;
		seen_nz_d    = seen_nz_q;
		byte0_d      = byte0_q;
		byte1_d      = byte1_q;
		byte2_d      = byte2_q;
		prev_d       = prev_q;
		hi_d         = hi_q;
		frame_d      = frame_q;
		frame_n_d    = frame_n_q;
		frame_idx_d  = frame_idx_q;
		tail_d       = tail_q;
		in_crc_d     = in_crc_q;
		crc_idx_d    = crc_idx_q;
		word_cnt_d   = word_cnt_q;
		word_idx_d   = word_idx_q;
		word7_d      = word7_q;
		stat_d       = stat_q;
		wr_word      = 1'b0;
		wr_idx       = '0;
		wr_data      = '0;
		pop          = 1'b0;
		emit         = 1'b0;
		e_kind       = KIND_TX;
		e_tx         = '0;
		e_val        = '0;
		e_st         = ST_OK;
		e_last       = 1'b0;

		s       = head.item.slave;
		f       = head.item.function_req;
		b       = head.item.rx_byte;
		qs      = head.item.quantity;
		len_raw = LEN_WRITE;
		known   = 1'b1;
		rd      = (func_q == FN_READ_HOLD) || (func_q == FN_READ_INPUT);
		k1      = {1'b0, rx_count_q} + 1'b1;
		k2      = {1'b0, rx_count_q} + 2'd2;
		off     = 9'(rx_count_q) - 9'd3;
		hl      = (9'(exp_len_q) - 9'd5) >> 1;
		st      = ST_OK;
		crc_ok  = 1'b0;
		cur_byte = frame_q[frame_idx_q];
		wl_next = words_left_q;

		case (state_q)
			S_DECODE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (head.item.req)
						REQ_START: begin
							if (s >= 8'd1 && s <= 8'd32) begin
								order_low_d = 1'b1;
							end else if (s >= 8'd33 && s <= 8'd96) begin
								order_low_d = 1'b0;
							end
							phase_d  = PH_IDLE;
							slave_d  = s;
							func_d   = f;
							tx_crc_d = CRC_INIT;
							if (f == FN_WRITE_MULTI && int'(qs) > MAX_WRITE_WORDS) begin
								qs = 7'(MAX_WRITE_WORDS);
							end
							qty_d       = qs;
							frame_d[0]  = s;
							frame_d[1]  = f;
							frame_d[2]  = head.item.address[15:8];
							frame_d[3]  = head.item.address[7:0];
							frame_d[4]  = 8'h00;
							frame_d[5]  = {1'b0, qs};
							frame_d[6]  = {qs, 1'b0};
							frame_n_d   = 3'd6;
							tail_d      = 1'b1;
							case (f)
								FN_READ_HOLD, FN_READ_INPUT: begin
									if (s >= 8'd1 && s <= 8'd32) begin
										len_raw = LEN_BAND1;
									end else if (s >= 8'd33 && s <= 8'd64) begin
										len_raw = LEN_BAND2;
									end else if (s >= 8'd65 && s <= 8'd96) begin
										len_raw = LEN_BAND3;
									end else begin
										len_raw = 9'd5 + {1'b0, qs, 1'b0};
									end
								end
								FN_WRITE_COIL, FN_WRITE_REG: begin
									frame_d[4] = head.item.data_word[15:8];
									frame_d[5] = head.item.data_word[7:0];
								end
								FN_EXC_STATUS: begin
									len_raw   = LEN_EXC;
									frame_n_d = 3'd2;
								end
								FN_DIAG: begin
									frame_d[2] = 8'h00;
									frame_d[3] = 8'h00;
									frame_d[5] = 8'h00;
								end
								FN_WRITE_MULTI: begin
									frame_n_d    = 3'd7;
									words_left_d = qs;
									tail_d       = (qs == '0);
								end
								default: begin
									known = 1'b0;
								end
							endcase
							if (!known) begin
								stat_d  = ST_BAD_FUNC;
								state_d = S_STATUS;
							end else begin
								exp_len_d = (len_raw > 9'(RX_BUF_BYTES)) ?
									CW'(RX_BUF_BYTES) : CW'(len_raw);
								frame_idx_d = '0;
								in_crc_d    = 1'b0;
								crc_idx_d   = 1'b0;
								state_d     = S_TX;
								if (tail_d) begin
									phase_d    = PH_RECV;
									rx_count_d = '0;
									seen_nz_d  = 1'b0;
									rx_crc_d   = CRC_INIT;
								end else begin
									phase_d = PH_WDATA;
								end
							end
						end
						REQ_WDATA: begin
							if (phase_q == PH_WDATA) begin
								frame_d[0] = head.item.data_word[15:8];
								frame_d[1] = head.item.data_word[7:0];
								frame_n_d  = 3'd2;
								if (words_left_q != '0) begin
									wl_next = words_left_q - 1'b1;
								end
								words_left_d = wl_next;
								tail_d       = (wl_next == '0);
								frame_idx_d  = '0;
								in_crc_d     = 1'b0;
								crc_idx_d    = 1'b0;
								state_d      = S_TX;
								if (wl_next == '0) begin
									phase_d    = PH_RECV;
									rx_count_d = '0;
									seen_nz_d  = 1'b0;
									rx_crc_d   = CRC_INIT;
								end
							end
						end
						REQ_RXBYTE: begin
							if (phase_q == PH_RECV && (seen_nz_q || b != 8'h00)) begin
								seen_nz_d  = 1'b1;
								rx_count_d = k1[CW-1:0];
								prev_d     = b;
								if (rx_count_q == CW'(0)) begin
									byte0_d = b;
								end
								if (rx_count_q == CW'(1)) begin
									byte1_d = b;
								end
								if (rx_count_q == CW'(2)) begin
									byte2_d = b;
								end
								// pack data bytes into words as they arrive
								if (9'(rx_count_q) >= 9'd3) begin
									if (!off[0]) begin
										hi_d = b;
									end else if (off[8:1] < 8'(MAX_READ_WORDS)) begin
										wr_word = 1'b1;
										wr_idx  = off[4:1];
										wr_data = {hi_q, b};
									end
								end
								if (k2 < {1'b0, exp_len_q}) begin
									rx_crc_d = crc_byte(rx_crc_q, b);
								end
								if (k1 >= {1'b0, exp_len_q}) begin
									phase_d = PH_IDLE;
									if (order_low_q) begin
										crc_ok = (prev_q == rx_crc_q[7:0]) && (b == rx_crc_q[15:8]);
									end else begin
										crc_ok = (prev_q == rx_crc_q[15:8]) && (b == rx_crc_q[7:0]);
									end
									if (byte0_q != slave_q) begin
										st = ST_WRONG_SLAVE;
									end else if (rd ? (byte1_q != FN_READ_HOLD &&
										byte1_q != FN_READ_INPUT) : (byte1_q != func_q)) begin
										st = ST_BAD_FRAME;
									end else if (!crc_ok) begin
										st = ST_BAD_FRAME;
									end
									stat_d     = st;
									word_idx_d = '0;
									word7_d    = 1'b0;
									if (9'(qty_q) < hl) begin
										hl = 9'(qty_q);
									end
									if (hl > 9'(MAX_READ_WORDS)) begin
										hl = 9'(MAX_READ_WORDS);
									end
									word_cnt_d = hl[3:0];
									state_d    = S_STATUS;
									if (st == ST_OK && rd && hl != '0) begin
										state_d = S_WORDS;
									end else if (st == ST_OK && func_q == FN_EXC_STATUS) begin
										word7_d    = 1'b1;
										word_cnt_d = 4'd1;
										state_d    = S_WORDS;
									end
								end
							end
						end
						default: begin
							if (phase_q != PH_IDLE) begin
								phase_d = PH_IDLE;
								stat_d  = ST_TIMEOUT;
								state_d = S_STATUS;
							end
						end
					endcase
				end
			end
			S_TX: begin
				if (slot_free) begin
					emit = 1'b1;
					if (!in_crc_q) begin
						e_tx        = cur_byte;
						tx_crc_d    = crc_byte(tx_crc_q, cur_byte);
						frame_idx_d = frame_idx_q + 1'b1;
						if (frame_idx_q == frame_n_q - 1'b1) begin
							if (tail_q) begin
								in_crc_d = 1'b1;
							end else begin
								e_last  = 1'b1;
								state_d = S_DECODE;
							end
						end
					end else begin
						// low byte first when the order flag is set, else high byte first
						e_tx      = (order_low_q == !crc_idx_q) ? tx_crc_q[7:0] : tx_crc_q[15:8];
						crc_idx_d = 1'b1;
						if (crc_idx_q) begin
							e_last  = 1'b1;
							state_d = S_DECODE;
						end
					end
				end
			end
			S_WORDS: begin
				if (slot_free) begin
					emit       = 1'b1;
					e_kind     = KIND_WORD;
					e_val      = word7_q ? {8'h00, byte2_q} : wmem_q[word_idx_q];
					word_idx_d = word_idx_q + 1'b1;
					if (word_idx_q == word_cnt_q - 1'b1) begin
						state_d = S_STATUS;
					end
				end
			end
			S_STATUS: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_kind  = KIND_STATUS;
					e_st    = stat_q;
					e_last  = 1'b1;
					state_d = S_DECODE;
				end
			end
			default: begin
				state_d = S_DECODE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		frame_q <= frame_d;
		if (wr_word) begin
			wmem_q[wr_idx] <= wr_data;
		end
		if (emit) begin
			kind_q <= e_kind;
			tx_q   <= e_tx;
			val_q  <= e_val;
			st_q   <= e_st;
			last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_DECODE;
			phase_q      <= PH_IDLE;
			order_low_q  <= 1'b0;
			slave_q      <= '0;
			func_q       <= '0;
			qty_q        <= '0;
			words_left_q <= '0;
			tx_crc_q     <= CRC_INIT;
			rx_crc_q     <= CRC_INIT;
			rx_count_q   <= '0;
			exp_len_q    <= '0;
			seen_nz_q    <= 1'b0;
			byte0_q      <= '0;
			byte1_q      <= '0;
			byte2_q      <= '0;
			prev_q       <= '0;
			hi_q         <= '0;
			frame_n_q    <= '0;
			frame_idx_q  <= '0;
			tail_q       <= 1'b0;
			in_crc_q     <= 1'b0;
			crc_idx_q    <= 1'b0;
			word_cnt_q   <= '0;
			word_idx_q   <= '0;
			word7_q      <= 1'b0;
			stat_q       <= ST_OK;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			order_low_q  <= order_low_d;
			slave_q      <= slave_d;
			func_q       <= func_d;
			qty_q        <= qty_d;
			words_left_q <= words_left_d;
			tx_crc_q     <= tx_crc_d;
			rx_crc_q     <= rx_crc_d;
			rx_count_q   <= rx_count_d;
			exp_len_q    <= exp_len_d;
			seen_nz_q    <= seen_nz_d;
			byte0_q      <= byte0_d;
			byte1_q      <= byte1_d;
			byte2_q      <= byte2_d;
			prev_q       <= prev_d;
			hi_q         <= hi_d;
			frame_n_q    <= frame_n_d;
			frame_idx_q  <= frame_idx_d;
			tail_q       <= tail_d;
			in_crc_q     <= in_crc_d;
			crc_idx_q    <= crc_idx_d;
			word_cnt_q   <= word_cnt_d;
			word_idx_q   <= word_idx_d;
			word7_q      <= word7_d;
			stat_q       <= stat_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign out_kind   = kind_q;
	assign tx_byte    = tx_q;
	assign data_value = val_q;
	assign status     = st_q;
	assign last       = last_q;

endmodule

// ----- design/mrmf_checker.sv -----
// port-level checks on the framer result channel, bound to the top level
`include "modbus_rtu_master_framer_macros.svh"

module mrmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  out_kind,
	input logic [7:0]  tx_byte,
	input logic [15:0] data_value,
	input logic [2:0]  status,
	input logic        last
);
	import mrmf_pkg::*;

	`MRMF_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(out_kind) && $stable(tx_byte) && $stable(data_value) && $stable(status) && $stable(last))
	`MRMF_ASSERT_IMP(a_status_last, clk, arst_n, res_valid && out_kind == KIND_STATUS, last && tx_byte == 8'h00 && data_value == 16'h0000)
	`MRMF_ASSERT_IMP(a_word_clean, clk, arst_n, res_valid && out_kind == KIND_WORD, !last && tx_byte == 8'h00 && status == ST_OK)
	`MRMF_ASSERT_IMP(a_tx_clean, clk, arst_n, res_valid && out_kind == KIND_TX, data_value == 16'h0000 && status == ST_OK)

endmodule

bind modbus_rtu_master_framer mrmf_checker u_mrmf_checker (.*);
